// ===== sv/scan_repulsive_force_accumulator_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scan repulsive force accumulator
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SCAN_REPULSIVE_FORCE_ACCUMULATOR_TOP_MACROS_SVH
`define SCAN_REPULSIVE_FORCE_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define SRFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srfa_pkg.sv =====
// ---------------------------------------------------------------------------
// srfa_pkg
// Shared types and constants of the scan repulsive force accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package srfa_pkg;

  localparam int InWordW  = 48;   // 44 bits of fields, byte padded
  localparam int OutWordW = 136;  // 132 bits of fields, byte padded

  localparam logic [15:0] ViewReset = 16'd2200;
  localparam logic [15:0] GainReset = 16'd2000;
  localparam logic [15:0] StepReset = 16'd182;

  // 1e9/2^9 and 5e5/2^5 scale factors of the force and potential numerators
  localparam logic [20:0] ForceScale = 21'd1953125;
  localparam logic [20:0] PotScale   = 21'd15625;

  localparam logic [31:0] CordicX0   = 32'd652032874;
  localparam logic [15:0] QuarterOff = 16'hC000;  // -90 deg

  localparam logic [3:0]  MulLast = 4'd10;
  localparam logic [6:0]  DivLast = 7'd74;        // 75 dividend bits
  localparam logic [3:0]  CordicLast = 4'd15;

  localparam logic [40:0] Cap40 = 41'h100_0000_0000;

  localparam logic [21:0] AtanTab [16] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
    22'd166669,  22'd83416,   22'd41718,  22'd20860,
    22'd10430,   22'd5215,    22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81
  };

  typedef enum logic [1:0] {
    CFG_VIEW = 2'd0,
    CFG_GAIN = 2'd1,
    CFG_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] view;
    logic [15:0] gain;
    logic [15:0] step;
  } cfg_t;

  typedef struct packed {
    logic        clr;
    logic        cls;
    logic        emit;
    logic [15:0] near_range;
    logic [11:0] near_ray;
    logic [15:0] heading;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_CORDIC,
    B_FX,
    B_FY,
    B_ACC,
    B_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ===== sv/srfa_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// srfa_cmd_fifo
// Short command queue between the ray front end and the force back end.
// ---------------------------------------------------------------------------
`default_nettype none

module srfa_cmd_fifo #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire srfa_pkg::cmd_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output srfa_pkg::cmd_t       data_o,
  output logic                 empty_o
);
  import srfa_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srfa_front.sv =====
// ---------------------------------------------------------------------------
// srfa_front
// Takes ray words, tracks the open obstacle and issues clear/close/emit
// commands.
// ---------------------------------------------------------------------------
`default_nettype none

module srfa_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srfa_pkg::cfg_t                cfg_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [srfa_pkg::InWordW-1:0]  s_axis_tdata,
  input  wire logic [0:0]                    s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  output logic                               push_o,
  output srfa_pkg::cmd_t                     cmd_o,
  input  wire logic                          full_i
);
  import srfa_pkg::*;

  logic        inside_q, inside_d;
  logic [15:0] near_q, near_d;
  logic [11:0] ray_q, ray_d;

  logic [15:0] range, rng_eff, near0;
  logic [11:0] ray, ray0;
  logic        first, last, in0, hit, cls, accept;

  assign range = s_axis_tdata[15:0];
  assign ray   = s_axis_tdata[27:16];
  assign first = s_axis_tuser[0];
  assign last  = s_axis_tlast;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rng_eff  = (range == 16'd0) ? 16'd1 : range;
    in0      = first ? 1'b0 : inside_q;
    near0    = first ? 16'd0 : near_q;
    ray0     = first ? 12'd0 : ray_q;
    hit      = range < cfg_i.view;
    inside_d = in0;
    near_d   = near0;
    ray_d    = ray0;
    cls      = 1'b0;
    if (hit) begin
      // earliest ray of the minimum wins
      if (!in0 || rng_eff < near0) begin
        near_d = rng_eff;
        ray_d  = ray;
      end
      inside_d = 1'b1;
    end else if (in0) begin
      cls      = 1'b1;
      inside_d = 1'b0;
    end
    if (last && inside_d) begin
      cls      = 1'b1;
      inside_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o.clr        = first;
    cmd_o.cls        = cls;
    cmd_o.emit       = last;
    cmd_o.near_range = near_d;
    cmd_o.near_ray   = ray_d;
    cmd_o.heading    = s_axis_tdata[43:28];
    push_o           = accept && (first || cls || last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      near_q   <= '0;
      ray_q    <= '0;
    end else if (accept) begin
      inside_q <= inside_d;
      near_q   <= near_d;
      ray_q    <= ray_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srfa_back.sv =====
// ---------------------------------------------------------------------------
// srfa_back
// Executes commands: clears sums, evaluates an obstacle's force and
// potential with a shared multiplier, a bit-serial divider and a CORDIC,
// and loads the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module srfa_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire srfa_pkg::cfg_t                 cfg_i,
  input  wire srfa_pkg::cmd_t                 cmd_i,
  input  wire logic                           empty_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [srfa_pkg::OutWordW-1:0]       m_axis_tdata
);
  import srfa_pkg::*;

  function automatic logic signed [31:0] trunc_shr(logic signed [31:0] v, logic [3:0] n);
    logic signed [31:0] q;
    logic [31:0]        msk;
    q   = v >>> n;
    msk = (32'd1 << n) - 32'd1;
    if (v[31] && ((v & msk) != 32'd0)) begin
      q = q + 32'sd1;
    end
    return q;
  endfunction

  function automatic logic [39:0] acc_force(logic [39:0] s, logic [41:0] m, logic add);
    logic signed [43:0] t;
    t = {{4{s[39]}}, s} + (add ? {2'b0, m} : -{2'b0, m});
    if (t > 44'sd549755813887) begin
      return 40'h7F_FFFF_FFFF;
    end else if (t < -44'sd549755813888) begin
      return 40'h80_0000_0000;
    end
    return t[39:0];
  endfunction

  back_state_e state_q, state_d;
  cmd_t        cmd_q;

  logic [3:0]  step_q;
  logic [6:0]  cnt_q;
  logic [3:0]  it_q;
  logic        div_p_q;

  logic [47:0] mul_a;
  logic [20:0] mul_b;
  logic [68:0] prod_w, prod_q;

  logic [31:0] t1_q, kd_q;
  logic [52:0] num_f_q;
  logic [61:0] num_p_q;
  logic [63:0] den_f_q, den_p_q;
  logic [15:0] ang_q;

  logic [74:0] dvd_q;
  logic [63:0] rem_q;
  logic [40:0] quo_q, f_q, p_q;
  logic        ovf_q;

  logic signed [31:0] x_q, y_q;
  logic signed [24:0] z_q;

  logic [39:0] sfx_q, sfy_q, spot_q;
  logic [11:0] nobs_q;

  logic        out_valid_q;
  logic [OutWordW-1:0] out_q;

  // derived
  logic [15:0] near_mm, diff;
  logic        live, out_load;
  logic [63:0] den;
  logic [64:0] sh;
  logic        ge;
  logic [63:0] rem_n;
  logic [40:0] quo_n, div_res;
  logic        ovf_n;
  logic signed [31:0] cx, sy, ax, ay;
  logic [15:0] cmag, smag;
  logic        cneg, sneg;
  logic [41:0] pot_sum;
  logic [11:0] nobs_base;

  assign near_mm = cmd_q.near_range;
  assign diff    = cfg_i.view - near_mm;
  assign live    = (cmd_i.near_range != 16'd0) && (cmd_i.near_range < cfg_i.view);

  // divider step
  always_comb begin
    den     = div_p_q ? den_p_q : den_f_q;
    sh      = {rem_q, dvd_q[74]};
    ge      = sh >= {1'b0, den};
    rem_n   = ge ? 64'(sh - {1'b0, den}) : sh[63:0];
    quo_n   = {quo_q[39:0], ge};
    ovf_n   = ovf_q | quo_q[40];
    div_res = (ovf_n || quo_n[40]) ? Cap40 : quo_n;
  end

  // quadrant fold and Q1.15 truncation
  always_comb begin
    unique case (ang_q[15:14])
      2'd0: begin cx = x_q;  sy = y_q;  end
      2'd1: begin cx = -y_q; sy = x_q;  end
      2'd2: begin cx = -x_q; sy = -y_q; end
      default: begin cx = y_q; sy = -x_q; end
    endcase
    ax   = cx[31] ? -cx : cx;
    ay   = sy[31] ? -sy : sy;
    cmag = ax[30:15];
    smag = ay[30:15];
    cneg = cx[31];
    sneg = sy[31];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.cls && live) begin
            state_d = B_MUL;
          end else if (cmd_i.emit) begin
            state_d = B_EMIT;
          end
        end
      end
      B_MUL: begin
        if (step_q == MulLast) state_d = B_DIV;
      end
      B_DIV: begin
        if (cnt_q == DivLast && div_p_q) state_d = B_CORDIC;
      end
      B_CORDIC: begin
        if (it_q == CordicLast) state_d = B_FX;
      end
      B_FX:  state_d = B_FY;
      B_FY:  state_d = B_ACC;
      B_ACC: state_d = cmd_q.emit ? B_EMIT : B_IDLE;
      B_EMIT: begin
        if (!out_valid_q || m_axis_tready) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    out_load = (state_q == B_EMIT) && (!out_valid_q || m_axis_tready);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      B_MUL: begin
        unique case (step_q)
          4'd0: begin mul_a = {32'b0, near_mm};     mul_b = {5'b0, near_mm}; end
          4'd1: begin mul_a = prod_q[47:0];         mul_b = {5'b0, near_mm}; end
          4'd2: begin mul_a = prod_q[47:0];         mul_b = {5'b0, cfg_i.view}; end
          4'd3: begin mul_a = {32'b0, cfg_i.gain};  mul_b = {5'b0, diff}; end
          4'd4: begin mul_a = prod_q[47:0];         mul_b = ForceScale; end
          4'd5: begin mul_a = {16'b0, kd_q};        mul_b = {5'b0, diff}; end
          4'd6: begin mul_a = prod_q[47:0];         mul_b = PotScale; end
          4'd7: begin mul_a = {16'b0, t1_q};        mul_b = {5'b0, cfg_i.view}; end
          4'd8: begin mul_a = prod_q[47:0];         mul_b = {5'b0, cfg_i.view}; end
          4'd9: begin mul_a = {36'b0, cmd_q.near_ray}; mul_b = {5'b0, cfg_i.step}; end
          default: ;
        endcase
      end
      B_FX: begin mul_a = {7'b0, f_q}; mul_b = {5'b0, cmag}; end
      B_FY: begin mul_a = {7'b0, f_q}; mul_b = {5'b0, smag}; end
      default: ;
    endcase
  end

  assign prod_w    = mul_a * mul_b;
  assign pot_sum   = {2'b0, spot_q} + {1'b0, p_q};
  assign nobs_base = cmd_i.clr ? 12'd0 : nobs_q;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      it_q        <= '0;
      div_p_q     <= 1'b0;
      sfx_q       <= '0;
      sfy_q       <= '0;
      spot_q      <= '0;
      nobs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          step_q <= '0;
          if (pop_o) begin
            if (cmd_i.clr) begin
              sfx_q  <= '0;
              sfy_q  <= '0;
              spot_q <= '0;
            end
            if (cmd_i.cls) begin
              nobs_q <= (nobs_base == 12'hFFF) ? nobs_base : nobs_base + 12'd1;
            end else begin
              nobs_q <= nobs_base;
            end
          end
        end
        B_MUL: begin
          step_q <= step_q + 4'd1;
          if (step_q == MulLast) begin
            cnt_q   <= '0;
            div_p_q <= 1'b0;
          end
        end
        B_DIV: begin
          cnt_q <= (cnt_q == DivLast) ? 7'd0 : cnt_q + 7'd1;
          if (cnt_q == DivLast) begin
            div_p_q <= 1'b1;
            it_q    <= '0;
          end
        end
        B_CORDIC: it_q <= it_q + 4'd1;
        B_FY: sfx_q <= acc_force(sfx_q, prod_q[56:15], cneg);
        B_ACC: begin
          sfy_q  <= acc_force(sfy_q, prod_q[56:15], sneg);
          spot_q <= (pot_sum > 42'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : pot_sum[39:0];
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_w;
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (out_load) begin
      out_q <= {4'b0, nobs_q, spot_q, sfy_q, sfx_q};
    end
    unique case (state_q)
      B_MUL: begin
        unique case (step_q)
          4'd1:  t1_q    <= prod_q[31:0];
          4'd3:  den_f_q <= prod_q[63:0];
          4'd4:  kd_q    <= prod_q[31:0];
          4'd5:  num_f_q <= prod_q[52:0];
          4'd7:  num_p_q <= prod_q[61:0];
          4'd9:  den_p_q <= prod_q[63:0];
          4'd10: begin
            ang_q <= prod_q[15:0] + cmd_q.heading + QuarterOff;
            dvd_q <= {5'b0, num_f_q, 17'b0};
            rem_q <= '0;
            quo_q <= '0;
            ovf_q <= 1'b0;
          end
          default: ;
        endcase
      end
      B_DIV: begin
        if (cnt_q == DivLast) begin
          if (div_p_q) begin
            p_q <= div_res;
            x_q <= CordicX0;
            y_q <= '0;
            z_q <= {3'b0, ang_q[13:0], 8'b0};
          end else begin
            f_q   <= div_res;
            dvd_q <= {num_p_q, 13'b0};
            rem_q <= '0;
            quo_q <= '0;
            ovf_q <= 1'b0;
          end
        end else begin
          dvd_q <= {dvd_q[73:0], 1'b0};
          rem_q <= rem_n;
          quo_q <= quo_n;
          ovf_q <= ovf_n;
        end
      end
      B_CORDIC: begin
        if (!z_q[24]) begin
          x_q <= x_q - trunc_shr(y_q, it_q);
          y_q <= y_q + trunc_shr(x_q, it_q);
          z_q <= z_q - $signed({3'b0, AtanTab[it_q]});
        end else begin
          x_q <= x_q + trunc_shr(y_q, it_q);
          y_q <= y_q - trunc_shr(x_q, it_q);
          z_q <= z_q + $signed({3'b0, AtanTab[it_q]});
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== sv/scan_repulsive_force_accumulator_top.sv =====
// Close: a word that closes a live obstacle holds the back end through taking the command,
//   11 multiply steps, two divider passes, 16 CORDIC turns, then B_FX, B_FY and B_ACC.
// Throughput: the front takes one word per cycle while the command queue has room;
//   the back end takes no new command until a close ends; the bit-serial divider dominates.
// Clear/emit words pop in B_IDLE; emits then load the result in B_EMIT; others never queue.
// Reset: async, active low; control registers return to defaults, all sums clear at once.
// ---------------------------------------------------------------------------
// scan_repulsive_force_accumulator_top
// Repulsive potential field accumulator over a laser scan: rays are grouped
// into obstacles up front, and each closed obstacle's force and potential
// are summed in the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_repulsive_force_accumulator_top #(
  parameter int QueueDepth = 2   // command queue entries
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  // ray words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // range_mm[15:0], ray_index[27:16], heading[43:28], zero pad
  input  wire logic [srfa_pkg::InWordW-1:0]  s_axis_tdata,
  // first_ray[0]
  input  wire logic [0:0]                    s_axis_tuser,
  input  wire logic                          s_axis_tlast,   // last_ray
  // result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // force_x[39:0], force_y[79:40], potential[119:80],
  // obstacle_count[131:120], zero pad
  output logic [srfa_pkg::OutWordW-1:0]      m_axis_tdata
);
  import srfa_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_push, cmd_head;
  logic push, full, pop, empty;

  // Config is taken every cycle; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view <= ViewReset;
      cfg_q.gain <= GainReset;
      cfg_q.step <= StepReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VIEW: cfg_q.view <= cfg_data_i;
        CFG_GAIN: cfg_q.gain <= cfg_data_i;
        CFG_STEP: cfg_q.step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: hit test, nearest tracking, command generation.
  srfa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .cmd_o         (cmd_push),
    .full_i        (full)
  );

  // Decouples the per-ray front from the slow close arithmetic.
  srfa_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (empty)
  );

  // Back: force/potential evaluation, saturating sums, output register.
  srfa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd_head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/srfa_checker.sv =====
// ---------------------------------------------------------------------------
// srfa_checker
// Port-level checks on the result stream of the accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

`include "scan_repulsive_force_accumulator_top_macros.svh"

module srfa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [srfa_pkg::OutWordW-1:0] m_axis_tdata
);
  import srfa_pkg::*;

  // stalled result word stays put
  `SRFA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed under stall")

  // nothing comes out right after reset release
  `SRFA_ASSERT_IMP(a_quiet_after_reset, !$past(rst_ni), !m_axis_tvalid, "result word right after reset")

  // no obstacle closed means nothing summed
  `SRFA_ASSERT_IMP(a_empty_scan_zero, m_axis_tvalid && (m_axis_tdata[131:120] == 12'd0), m_axis_tdata[119:0] == 120'd0, "sums nonzero with zero obstacles")

endmodule

bind scan_repulsive_force_accumulator_top srfa_checker u_srfa_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// Testbench for scan_repulsive_force_accumulator_top
// Feeds laser rays (directed rows, then random scans over several register
// settings) and checks every result word against typed sums or a cycle-free
// model of obstacle grouping, force/potential arithmetic and CORDIC direction.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srfa_pkg::*;

  localparam longint unsigned Cap    = 64'h100_0000_0000;
  localparam longint          ForceHi = 64'sd549755813887;
  localparam longint          ForceLo = -64'sd549755813888;
  localparam int              CycleLimit = 4_000_000;
  localparam int              DrainCycles = 1000;  // > a full queue of closes plus one

  typedef struct packed {
    logic signed [39:0] fx;
    logic signed [39:0] fy;
    logic [39:0]        pot;
    logic [11:0]        cnt;
  } scan_sum_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [15:0] cdata;
    logic [15:0] range_mm;
    logic [11:0] ray;
    logic [15:0] heading;
    bit          first;
    bit          last;
    bit          typed;      // expectation written by hand
    scan_sum_t   exp;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [InWordW-1:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [OutWordW-1:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  scan_repulsive_force_accumulator_top u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // ---- model state ----
  logic [15:0] view_mm, gain, step;
  bit          in_obst;
  logic [15:0] near_d;
  logic [11:0] near_ray;
  longint      acc_fx, acc_fy;
  longint unsigned acc_pot;
  int          n_closed;

  scan_sum_t   sums_due[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          n_rays = 0;
  int          n_closes = 0;
  bit          quiet = 1'b0;   // no idling on either side
  int          cycles = 0;

  // floor(t * 2^s / den), capped at 2^40
  function automatic longint unsigned scaled_quot(longint unsigned t,
                                                  longint unsigned den, int s);
    longint unsigned q, rem;
    q = t / den;
    rem = t % den;
    if (q >= (Cap >> s)) return Cap;
    for (int i = 0; i < s; i++) begin
      q = q << 1;
      if (rem >= den - rem) begin
        q = q | 1;
        rem = rem - (den - rem);
      end else begin
        rem = rem << 1;
      end
    end
    return (q > Cap) ? Cap : q;
  endfunction

  // cos/sin in Q1.15 of an angle in 1/65536 turn
  task automatic unit_dir(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, nx, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'({ang[13:0], 8'h00});
    for (int i = 0; i < 16; i++) begin
      dx = y / (64'sd1 << i);
      dy = x / (64'sd1 << i);
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z = z - longint'(AtanTab[i]);
      end else begin
        nx = x + dx; y = y - dy; z = z + longint'(AtanTab[i]);
      end
      x = nx;
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = c / 32768;
    s = s / 32768;
  endtask

  function automatic longint clamp_force(longint v);
    return (v > ForceHi) ? ForceHi : ((v < ForceLo) ? ForceLo : v);
  endfunction

  task automatic close_obstacle(input logic [15:0] heading);
    longint unsigned d, dv, kr, diff, f, p, a64;
    longint c, s, fs;
    d = near_d;
    dv = view_mm;
    kr = gain;
    if (n_closed < 4095) n_closed++;
    n_closes++;
    if (d >= 1 && d < dv) begin
      diff = dv - d;
      f = scaled_quot(kr * diff * 1953125, d * d * d * dv, 17);
      p = scaled_quot(kr * diff * diff * 15625, d * d * dv * dv, 13);
      a64 = longint'(near_ray) * longint'(step) + longint'(heading) + 49152;
      unit_dir(a64[15:0], c, s);
      fs = longint'(f);
      acc_fx = clamp_force(acc_fx - (fs * c) / 32768);
      acc_fy = clamp_force(acc_fy - (fs * s) / 32768);
      acc_pot = acc_pot + p;
      if (acc_pot > Cap - 1) acc_pot = Cap - 1;
    end
    in_obst = 1'b0;
  endtask

  function automatic void clear_scan();
    in_obst = 1'b0;
    near_d = '0;
    near_ray = '0;
    acc_fx = 0;
    acc_fy = 0;
    acc_pot = 0;
    n_closed = 0;
  endfunction

  // one accepted ray; returns 1 with the scan sums on the last ray
  task automatic predict_ray(input logic [15:0] range_mm, input logic [11:0] ray,
                             input logic [15:0] heading, input bit first,
                             input bit last, output bit emits, output scan_sum_t r);
    logic [15:0] d;
    d = (range_mm == 0) ? 16'd1 : range_mm;
    if (first) clear_scan();
    if (range_mm < view_mm) begin
      if (!in_obst || d < near_d) begin
        near_d = d;
        near_ray = ray;
      end
      in_obst = 1'b1;
    end else if (in_obst) begin
      close_obstacle(heading);
    end
    emits = last;
    r = '0;
    if (last) begin
      if (in_obst) close_obstacle(heading);
      r.fx  = acc_fx[39:0];
      r.fy  = acc_fy[39:0];
      r.pot = acc_pot[39:0];
      r.cnt = n_closed[11:0];
    end
  endtask

  // ---- drivers ----
  task automatic send_ray(input logic [15:0] range_mm, input logic [11:0] ray,
                          input logic [15:0] heading, input bit first, input bit last,
                          input bit typed = 0, input scan_sum_t typed_exp = '0);
    bit emits;
    scan_sum_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, heading, ray, range_mm};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_rays++;
    predict_ray(range_mm, ray, heading, first, last, emits, r);
    if (emits) sums_due.push_back(typed ? typed_exp : r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_VIEW: view_mm = val;
      CFG_GAIN: gain = val;
      default:  step = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---- result side: random stall bursts ----
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    scan_sum_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[131:0];
      got.fx  = m_axis_tdata[39:0];
      got.fy  = m_axis_tdata[79:40];
      got.pot = m_axis_tdata[119:80];
      got.cnt = m_axis_tdata[131:120];
      n_results++;
      if (sums_due.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = sums_due.pop_front();
        if (got.fx !== want.fx) begin
          $error("force_x: expected %0d, got %0d", want.fx, got.fx);
          n_errors++;
        end
        if (got.fy !== want.fy) begin
          $error("force_y: expected %0d, got %0d", want.fy, got.fy);
          n_errors++;
        end
        if (got.pot !== want.pot) begin
          $error("potential: expected %0d, got %0d", want.pot, got.pot);
          n_errors++;
        end
        if (got.cnt !== want.cnt) begin
          $error("obstacle_count: expected %0d, got %0d", want.cnt, got.cnt);
          n_errors++;
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---- directed table ----
  function automatic dir_row_t blank_row();
    dir_row_t r;
    r.is_cfg   = 1'b0;
    r.idx      = CFG_VIEW;
    r.cdata    = '0;
    r.range_mm = '0;
    r.ray      = '0;
    r.heading  = '0;
    r.first    = 1'b0;
    r.last     = 1'b0;
    r.typed    = 1'b0;
    r.exp      = '0;
    return r;
  endfunction

  function automatic dir_row_t ray_row(logic [15:0] rg, logic [11:0] ray, logic [15:0] hd,
                                       bit first, bit last);
    dir_row_t r;
    r = blank_row();
    r.range_mm = rg; r.ray = ray; r.heading = hd; r.first = first; r.last = last;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e idx, logic [15:0] val);
    dir_row_t r;
    r = blank_row();
    r.is_cfg = 1'b1; r.idx = idx; r.cdata = val;
    return r;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t r, logic [11:0] cnt);
    r.typed = 1'b1;
    r.exp = '0;
    r.exp.cnt = cnt;
    return r;
  endfunction

  dir_row_t dir_rows[$];

  // random scan: mostly well formed, some broken or noisy
  task automatic random_scan();
    int len;
    logic [11:0] ray;
    logic [15:0] rg, hd;
    bit first, last, drop_first, drop_last;
    len = $urandom_range(2, 24);
    ray = 12'($urandom_range(0, 4095));
    hd = 16'($urandom);
    drop_first = ($urandom_range(0, 19) == 0);
    drop_last  = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       rg = 16'd0;
        1:       rg = 16'($urandom);
        2, 3, 4: rg = (view_mm > 1) ? 16'($urandom_range(1, view_mm - 1)) : 16'd0;
        5:       rg = (view_mm > 20) ? 16'($urandom_range(view_mm - 20, view_mm - 1))
                                     : 16'd0;
        default: rg = 16'($urandom_range(view_mm, 65535));
      endcase
      first = (i == 0) && !drop_first;
      last  = (i == len - 1) && !drop_last;
      if ($urandom_range(0, 19) == 0) begin
        // noise word
        first = 1'($urandom_range(0, 1));
        last  = 1'($urandom_range(0, 1));
        send_ray(rg, 12'($urandom), 16'($urandom), first, last);
      end else begin
        send_ray(rg, ray, hd, first, last);
      end
      ray = ray + 12'd1;
      if ($urandom_range(0, 3) == 0) hd = hd + 16'($urandom_range(0, 2000));
    end
  endtask

  initial begin
    int phase_items;
    logic [15:0] pv [5], pg [5], ps [5];

    view_mm = ViewReset;
    gain = GainReset;
    step = StepReset;
    clear_scan();

    // after reset: nothing hit
    dir_rows.push_back(typed_row(ray_row(16'hFFFF, 12'd0, 16'd0, 1, 1), 12'd0));
    // tiny range, full heading range
    dir_rows.push_back(ray_row(16'd0, 12'd0, 16'hFFFF, 1, 1));
    // equal nearest over two rays, closed by a free ray
    dir_rows.push_back(ray_row(16'd1000, 12'd5, 16'd100, 1, 0));
    dir_rows.push_back(ray_row(16'd1000, 12'd6, 16'd100, 0, 0));
    dir_rows.push_back(ray_row(16'd3000, 12'd7, 16'hFFFF, 0, 0));
    // obstacle open at the last ray
    dir_rows.push_back(ray_row(16'd500, 12'hFFF, 16'h8000, 0, 0));
    dir_rows.push_back(ray_row(16'd2199, 12'd0, 16'h4000, 0, 1));
    // scan without a first ray keeps summing
    dir_rows.push_back(ray_row(16'd1, 12'd1, 16'd0, 0, 1));
    // threshold moved while an obstacle is open: counted, adds nothing
    dir_rows.push_back(ray_row(16'd2000, 12'd3, 16'd0, 1, 0));
    dir_rows.push_back(cfg_row(CFG_VIEW, 16'd100));
    dir_rows.push_back(typed_row(ray_row(16'hFFFF, 12'd4, 16'd0, 0, 1), 12'd1));
    // zero gain
    dir_rows.push_back(cfg_row(CFG_GAIN, 16'd0));
    dir_rows.push_back(typed_row(ray_row(16'd5, 12'd9, 16'd0, 1, 1), 12'd1));
    // saturation: largest gain and view, nearest obstacles
    dir_rows.push_back(cfg_row(CFG_GAIN, 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_VIEW, 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_STEP, 16'hFFFF));
    dir_rows.push_back(ray_row(16'd0, 12'd0, 16'd0, 1, 0));
    dir_rows.push_back(ray_row(16'hFFFF, 12'd1, 16'd0, 0, 0));
    dir_rows.push_back(ray_row(16'd1, 12'hFFF, 16'hFFFF, 0, 0));
    dir_rows.push_back(ray_row(16'hFFFF, 12'd0, 16'd0, 0, 0));
    dir_rows.push_back(ray_row(16'd1, 12'd2048, 16'h2000, 0, 0));
    dir_rows.push_back(ray_row(16'd0, 12'd2049, 16'h2000, 0, 1));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].cdata);
      end else begin
        send_ray(dir_rows[i].range_mm, dir_rows[i].ray, dir_rows[i].heading,
                 dir_rows[i].first, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // register settings per random phase; extremes first
    pv = '{ViewReset, 16'hFFFF, 16'd1, 16'd0, 16'd0};
    pg = '{GainReset, 16'hFFFF, 16'd0, 16'd0, 16'd0};
    ps = '{StepReset, 16'd0, 16'hFFFF, 16'd0, 16'd0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph >= 3) begin
        pv[ph] = (ph == 3) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(500, 6000));
        pg[ph] = 16'($urandom);
        ps[ph] = 16'($urandom);
      end
      drain();
      write_reg(CFG_VIEW, pv[ph]);
      write_reg(CFG_GAIN, pg[ph]);
      write_reg(CFG_STEP, ps[ph]);
      if (ph == 4) quiet = 1'b1;
      phase_items = n_rays + 400;
      while (n_rays < phase_items) random_scan();
    end

    drain();
    $display("Covered %0d rays, %0d obstacle closes, %0d result words checked",
             n_rays, n_closes, n_results);
    $display("over 5 register settings plus directed edge-case rows.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
